// ===== rtl/azcl_pkg.sv =====
// azcl_pkg: shared types and constants for the adc zone classifier with latch
// used by azcl_engine and adc_zone_classifier_latch
// no dependencies
`timescale 1ns / 1ps

package azcl_pkg;

   // field widths
   localparam int TIME_W    = 32;
   localparam int VALUE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 56;   // 49 payload bits padded to whole bytes
   localparam int RSP_DATA_W = 24;   // 23 payload bits padded to whole bytes

   // request kind carried in tuser
   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_CLEAR  = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_FAULT     = 3'd2,
      STATUS_BUSY      = 3'd3,
      STATUS_NOT_READY = 3'd4
   } status_type;

   // classification zones
   typedef enum logic [1:0] {
      ZONE_SAFE      = 2'd0,
      ZONE_WARNING   = 2'd1,
      ZONE_DANGER    = 2'd2,
      ZONE_EMERGENCY = 2'd3
   } zone_type;

   // condition of the held sample
   typedef enum logic [1:0] {
      COND_EMPTY = 2'd0,
      COND_VALID = 2'd1,
      COND_FAULT = 2'd2
   } cond_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAFE_UPPER      = 3'd0,
      CSR_WARNING_UPPER   = 3'd1,
      CSR_EMERGENCY_LOWER = 3'd2,
      CSR_RANGE_LIMIT     = 3'd3,
      CSR_SAMPLE_PERIOD   = 3'd4
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [VALUE_W-1:0] SAFE_UPPER_RST      = 16'd1024;
   localparam logic [VALUE_W-1:0] WARNING_UPPER_RST   = 16'd2048;
   localparam logic [VALUE_W-1:0] EMERGENCY_LOWER_RST = 16'd3072;
   localparam logic [VALUE_W-1:0] RANGE_LIMIT_RST     = 16'd4096;
   localparam logic [VALUE_W-1:0] SAMPLE_PERIOD_RST   = 16'd10;

   // one request transaction
   typedef struct packed {
      req_kind_type        req_type;
      logic                sample_fault;
      logic [VALUE_W-1:0]  sample_value;
      logic [TIME_W-1:0]   now_time;
   } req_item_type;

   // one result transaction, first field in the highest bits
   typedef struct packed {
      logic                latched;
      zone_type            zone;
      logic [VALUE_W-1:0]  level;
      logic                sample_taken;
      status_type          status;
   } rsp_item_type;

endpackage

// ===== rtl/adc_zone_classifier_latch.sv =====
// adc_zone_classifier_latch: top level with request register, engine and
// two-entry result buffer
// depends on azcl_pkg and azcl_engine
`timescale 1ns / 1ps

// Takes one request transaction per cycle (sample event or latch clear) while
// req_tready is high, and returns exactly one result per request, in order. A
// request waits in the request register, where the engine classifies it against
// the held snapshot and updates that snapshot; the result is then registered in
// the output register, or in the skid entry behind it, and rsp_tvalid rises
// once a result sits in the output register. The snapshot update is a loop
// through the snapshot registers alone, so one request per cycle is sustained
// while the skid entry stays free. A two-entry output buffer keeps req_tready
// free of any path from rsp_tready and lets a new request in while a result
// waits. Configuration writes must only happen while no request is in flight.
module adc_zone_classifier_latch import azcl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // now_time, sample_value, sample_fault
   input  logic                  req_tuser,  // req_type
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // status, sample_taken, level, zone, latched
   // configuration port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VALUE_W-1:0]    csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff, skid_item_in;
   rsp_item_type result;
   logic         push;
   logic         pop;
   logic         req_fire;

   // handshake
   assign push       = in_valid_ff && !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;
   assign req_tready = !in_valid_ff || !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // request register
   assign in_valid_in = req_fire || (in_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.req_type     <= req_kind_type'(req_tuser);
         in_item_ff.now_time     <= req_tdata[TIME_W-1:0];
         in_item_ff.sample_value <= req_tdata[TIME_W+VALUE_W-1:TIME_W];
         in_item_ff.sample_fault <= req_tdata[TIME_W+VALUE_W];
      end
   end

   azcl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item_fire (push),
      .item      (in_item_ff),
      .result    (result)
   );

   // two-entry output buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_item_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_item_in  = result;
         end else begin
            out_valid_in = 1'b1;
            out_item_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(rsp_item_type)){1'b0}}, out_item_ff};

`ifndef SYNTHESIS
   // the skid entry is only used behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // an emergency zone always shows the latch set
   a_emergency_latched: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.zone == ZONE_EMERGENCY) |-> out_item_ff.latched)
      else $error("emergency zone reported without latch");

   // a processed sample reports ok or fault only
   a_taken_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.sample_taken) |->
         (out_item_ff.status == STATUS_OK || out_item_ff.status == STATUS_FAULT))
      else $error("processed sample with unexpected status");

   // a result enters the buffer the cycle after a request reaches the engine
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> (out_valid_ff || skid_valid_ff))
      else $error("result lost from buffer");
`endif

endmodule

// ===== rtl/azcl_engine.sv =====
// azcl_engine: configuration registers, held snapshot state and the
// per-transaction classification and latch logic
// depends on azcl_pkg
`timescale 1ns / 1ps

module azcl_engine import azcl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_wdata,
   input  logic                 item_fire,
   input  req_item_type         item,
   output rsp_item_type         result
);

   // configuration registers
   logic [VALUE_W-1:0] safe_upper_ff;
   logic [VALUE_W-1:0] warning_upper_ff;
   logic [VALUE_W-1:0] emergency_lower_ff;
   logic [VALUE_W-1:0] range_limit_ff;
   logic [VALUE_W-1:0] sample_period_ff;

   // snapshot state
   logic [TIME_W-1:0]  last_time_ff,  last_time_in;
   logic [VALUE_W-1:0] held_level_ff, held_level_in;
   zone_type           held_zone_ff,  held_zone_in;
   logic               latch_ff,      latch_in;
   cond_type           cond_ff,       cond_in;

   logic               cfg_ok;
   logic [TIME_W-1:0]  elapsed;
   logic               due;
   logic [VALUE_W-1:0] ceil_value;
   logic [VALUE_W-1:0] clamped;
   zone_type           new_zone;
   status_type         status;
   logic               taken;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_upper_ff      <= SAFE_UPPER_RST;
         warning_upper_ff   <= WARNING_UPPER_RST;
         emergency_lower_ff <= EMERGENCY_LOWER_RST;
         range_limit_ff     <= RANGE_LIMIT_RST;
         sample_period_ff   <= SAMPLE_PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAFE_UPPER:      safe_upper_ff      <= csr_wdata;
            CSR_WARNING_UPPER:   warning_upper_ff   <= csr_wdata;
            CSR_EMERGENCY_LOWER: emergency_lower_ff <= csr_wdata;
            CSR_RANGE_LIMIT:     range_limit_ff     <= csr_wdata;
            CSR_SAMPLE_PERIOD:   sample_period_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // thresholds must be ordered and nonzero where required
   assign cfg_ok = (sample_period_ff != '0) && (range_limit_ff != '0) &&
                   (safe_upper_ff <= warning_upper_ff) &&
                   (warning_upper_ff <= emergency_lower_ff) &&
                   (emergency_lower_ff <= range_limit_ff);

   // wrapping due test
   assign elapsed = item.now_time - last_time_ff;
   assign due     = elapsed >= {{(TIME_W-VALUE_W){1'b0}}, sample_period_ff};

   // clamp to the top of the converter range
   assign ceil_value = range_limit_ff - VALUE_W'(1);
   assign clamped    = (item.sample_value > ceil_value) ? ceil_value : item.sample_value;

   // zone classification
   always_comb begin
      priority if (clamped < safe_upper_ff)
         new_zone = ZONE_SAFE;
      else if (clamped < warning_upper_ff)
         new_zone = ZONE_WARNING;
      else if (clamped < emergency_lower_ff)
         new_zone = ZONE_DANGER;
      else
         new_zone = ZONE_EMERGENCY;
   end

   // next snapshot and status
   always_comb begin
      last_time_in  = last_time_ff;
      held_level_in = held_level_ff;
      held_zone_in  = held_zone_ff;
      latch_in      = latch_ff;
      cond_in       = cond_ff;
      taken         = 1'b0;
      status        = STATUS_NOT_READY;
      if (cfg_ok) begin
         if (item.req_type == REQ_SAMPLE) begin
            if (due) begin
               last_time_in = item.now_time;
               taken        = 1'b1;
               if (item.sample_fault) begin
                  // fail closed
                  held_level_in = '0;
                  held_zone_in  = ZONE_EMERGENCY;
                  latch_in      = 1'b1;
                  cond_in       = COND_FAULT;
               end else begin
                  held_level_in = clamped;
                  held_zone_in  = new_zone;
                  cond_in       = COND_VALID;
                  if (new_zone == ZONE_EMERGENCY)
                     latch_in = 1'b1;
               end
            end
            unique case (cond_in)
               COND_VALID: status = STATUS_OK;
               COND_FAULT: status = STATUS_FAULT;
               default:    status = STATUS_EMPTY;
            endcase
         end else begin
            // latch clear request
            priority if (cond_ff == COND_VALID && held_zone_ff != ZONE_EMERGENCY) begin
               latch_in = 1'b0;
               status   = STATUS_OK;
            end else if (cond_ff == COND_VALID) begin
               status = STATUS_BUSY;
            end else if (cond_ff == COND_FAULT) begin
               status = STATUS_FAULT;
            end else begin
               status = STATUS_EMPTY;
            end
         end
      end
   end

   // state update on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff  <= '0;
         held_level_ff <= '0;
         held_zone_ff  <= ZONE_SAFE;
         latch_ff      <= 1'b0;
         cond_ff       <= COND_EMPTY;
      end else if (item_fire) begin
         last_time_ff  <= last_time_in;
         held_level_ff <= held_level_in;
         held_zone_ff  <= held_zone_in;
         latch_ff      <= latch_in;
         cond_ff       <= cond_in;
      end
   end

   assign result.status       = status;
   assign result.sample_taken = taken;
   assign result.level        = held_level_in;
   assign result.zone         = held_zone_in;
   assign result.latched      = latch_in;

endmodule
